// ===== rtl/sha_pkg.sv =====
package sha_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned BlockWords = 16;
	localparam int unsigned Rounds = 64;
	localparam int unsigned DigestWords = 8;

	typedef logic [WordW-1:0] word_t;

	// one queue entry: a block word, and a mark on the final word of a message
	typedef struct packed {
		word_t word;
		logic  fin;
	} qent_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MARK,
		F_ZERO,
		F_LENHI,
		F_LENLO
	} fstate_t;

	typedef enum logic [1:0] {
		C_LOAD,
		C_ROUND,
		C_UPDATE,
		C_EMIT
	} cstate_t;

	localparam word_t MarkWord = 32'h8000_0000;
	localparam logic [7:0] MarkByte = 8'h80;

	function automatic word_t init_hash(input logic [2:0] idx);
		word_t r;
		unique case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			3'd7: r = 32'h5be0cd19;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic word_t round_k(input logic [5:0] idx);
		word_t r;
		unique case (idx)
			6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
			6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
			6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
			6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
			6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (WordW - n));
	endfunction

endpackage

// ===== rtl/sha_fifo.sv =====
module sha_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sha_pkg::qent_t push_data,
	output logic           full,
	input  logic           pop,
	output sha_pkg::qent_t pop_data,
	output logic           not_empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	sha_pkg::qent_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop && not_empty) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push && !full, pop && not_empty})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/sha_front.sv =====
module sha_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [31:0]    data_word,
	input  logic [2:0]     byte_count,
	input  logic           is_last,
	output logic           push,
	output sha_pkg::qent_t push_data,
	input  logic           full
);

	sha_pkg::fstate_t state_q, state_d;
	logic [3:0]  fill_q;
	logic [63:0] bits_q;
	logic        accept;
	logic [2:0]  cnt;
	sha_pkg::word_t tail;

	// saturate the byte count and place the marker after the valid bytes
	always_comb begin
		cnt = (byte_count > 3'd4) ? 3'd4 : byte_count;
		unique case (cnt)
			3'd0: tail = sha_pkg::MarkWord;
			3'd1: tail = {data_word[31:24], sha_pkg::MarkByte, 16'h0};
			3'd2: tail = {data_word[31:16], sha_pkg::MarkByte, 8'h0};
			3'd3: tail = {data_word[31:8], sha_pkg::MarkByte};
			default: tail = data_word;
		endcase
	end

	assign accept = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		push = 1'b0;
		push_data = '{word: '0, fin: 1'b0};
		unique case (state_q)
			sha_pkg::F_IDLE: begin
				in_stall = full;
				push = accept;
				push_data.word = is_last ? tail : data_word;
				if (accept && is_last) begin
					state_d = (cnt == 3'd4) ? sha_pkg::F_MARK : sha_pkg::F_ZERO;
				end
			end
			sha_pkg::F_MARK: begin
				push = 1'b1;
				push_data.word = sha_pkg::MarkWord;
				if (!full) begin
					state_d = sha_pkg::F_ZERO;
				end
			end
			sha_pkg::F_ZERO: begin
				// zero words until two slots remain in the block
				if (fill_q == 4'd14) begin
					state_d = sha_pkg::F_LENHI;
				end else begin
					push = 1'b1;
				end
			end
			sha_pkg::F_LENHI: begin
				push = 1'b1;
				push_data.word = bits_q[63:32];
				if (!full) begin
					state_d = sha_pkg::F_LENLO;
				end
			end
			sha_pkg::F_LENLO: begin
				push = 1'b1;
				push_data = '{word: bits_q[31:0], fin: 1'b1};
				if (!full) begin
					state_d = sha_pkg::F_IDLE;
				end
			end
			default: state_d = sha_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bits_q <= '0;
		end else begin
			if (push && !full) begin
				fill_q <= fill_q + 1'b1;
			end
			if (accept) begin
				bits_q <= bits_q + (is_last ? {58'h0, cnt, 3'b000} : 64'd32);
			end else if (state_q == sha_pkg::F_LENLO && !full) begin
				bits_q <= '0;
			end
		end
	end

endmodule

// ===== rtl/sha_core.sv =====
module sha_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  sha_pkg::qent_t q_data,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [31:0]    digest_word,
	output logic [2:0]     word_index,
	output logic           last_word
);

	sha_pkg::cstate_t state_q, state_d;
	sha_pkg::word_t h_q [8];
	sha_pkg::word_t v_q [8];
	sha_pkg::word_t w_q [16];
	logic [5:0] rnd_q;
	logic [3:0] cnt_q;
	logic [2:0] idx_q;
	logic       fin_q;
	logic       out_load;
	logic       take;

	sha_pkg::word_t s0, s1, w_new, big0, big1, ch, maj, t1, t2;

	// message schedule on a sliding window of sixteen words
	always_comb begin
		s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		big1 = sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11)
			^ sha_pkg::rotr(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + big1 + ch + sha_pkg::round_k(rnd_q) + w_q[0];
		big0 = sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13)
			^ sha_pkg::rotr(v_q[0], 22);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = big0 + maj;
	end

	assign q_pop = (state_q == sha_pkg::C_LOAD);
	assign take = q_pop && q_valid;
	assign out_load = (state_q == sha_pkg::C_EMIT) && (!out_valid || !out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha_pkg::C_LOAD: begin
				if (take && cnt_q == 4'd15) begin
					state_d = sha_pkg::C_ROUND;
				end
			end
			sha_pkg::C_ROUND: begin
				if (rnd_q == 6'd63) begin
					state_d = sha_pkg::C_UPDATE;
				end
			end
			sha_pkg::C_UPDATE: begin
				state_d = fin_q ? sha_pkg::C_EMIT : sha_pkg::C_LOAD;
			end
			sha_pkg::C_EMIT: begin
				if (out_load && idx_q == 3'd7) begin
					state_d = sha_pkg::C_LOAD;
				end
			end
			default: state_d = sha_pkg::C_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::C_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// working variables, schedule window and digest output register
	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= q_data.word;
			fin_q <= q_data.fin;
			if (cnt_q == 4'd15) begin
				for (int i = 0; i < 8; i++) begin
					v_q[i] <= h_q[i];
				end
			end
		end else if (state_q == sha_pkg::C_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (out_load) begin
			digest_word <= h_q[idx_q];
			word_index <= idx_q;
			last_word <= (idx_q == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha_pkg::init_hash(3'(i));
			end
			rnd_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (take) begin
				cnt_q <= cnt_q + 1'b1;
				rnd_q <= '0;
			end
			if (state_q == sha_pkg::C_ROUND) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (state_q == sha_pkg::C_UPDATE) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
				idx_q <= '0;
			end
			if (out_load) begin
				out_valid <= 1'b1;
				idx_q <= idx_q + 1'b1;
				if (idx_q == 3'd7) begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= sha_pkg::init_hash(3'(i));
					end
				end
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha_pkg::C_ROUND && rnd_q == 6'd63) |=> state_q == sha_pkg::C_UPDATE)
		else $error("round loop did not end after the last round");

	a_block_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha_pkg::C_ROUND) |-> cnt_q == 4'd0)
		else $error("compression started on a partial block");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_word) |-> word_index == 3'd7)
		else $error("final digest beat at wrong position");

	a_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != sha_pkg::C_LOAD) |-> !q_pop)
		else $error("queue popped while compressing or emitting");

endmodule

// ===== rtl/sha256_hash_engine.sv =====
// SHA-256 hash engine. The message enters as big-endian 32-bit words, one per
// input beat, first byte in bits 31..24; every beat counts four bytes except
// the one with is_last set, which carries byte_count (0..4, larger values
// count as 4) leading bytes and may carry none. After the last beat the block
// pads the message, folds in the 64-bit bit length and returns the digest as
// eight output beats, word_index 0 first, last_word on the eighth, then starts
// over for the next message. A front end turns input beats into block words
// (adding the 0x80 marker, zero fill and length words) and feeds a short queue;
// the compression core behind it loads sixteen words, one per cycle while the
// queue holds them, then runs 64 rounds at one round per cycle and updates the
// hash. The core takes no words from the queue while it runs rounds, updates
// or emits the digest. A final block adds the padding words and the eight
// digest output beats. Output beats sit in a register, so a stalled digest
// does not hold up the input side while the queue has room.
module sha256_hash_engine #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	// front end to queue
	logic           push;
	logic           full;
	sha_pkg::qent_t push_data;

	// queue to core
	logic           pop;
	logic           not_empty;
	sha_pkg::qent_t pop_data;

	sha_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_word (data_word),
		.byte_count(byte_count),
		.is_last   (is_last),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	sha_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (pop_data),
		.not_empty(not_empty)
	);

	// core holds the chaining hash and the digest output register
	sha_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (not_empty),
		.q_data     (pop_data),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digest_word(digest_word),
		.word_index (word_index),
		.last_word  (last_word)
	);

endmodule

// ===== tb/sha256_checker.sv =====
module sha256_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        is_last,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int          fail_count,
	output int          pending_digest_words,
	output int          messages_hashed
);

	typedef struct packed {
		sha_pkg::word_t word;
		logic [2:0]     idx;
		logic           fin;
	} digest_beat_t;

	sha_pkg::word_t hash_state [sha_pkg::DigestWords];
	sha_pkg::word_t blk [sha_pkg::BlockWords];
	int unsigned    fill;
	logic [63:0]    bit_len;
	digest_beat_t   digest_queue [$];

	function automatic sha_pkg::word_t k_const(input int i);
		sha_pkg::word_t kt [64] = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
			32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
			32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
			32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
			32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return kt[i];
	endfunction

	function automatic sha_pkg::word_t ror(input sha_pkg::word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic sha_pkg::word_t iv(input int i);
		sha_pkg::word_t ivt [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		return ivt[i];
	endfunction

	task automatic fold_block();
		sha_pkg::word_t w [64];
		sha_pkg::word_t v [8];
		sha_pkg::word_t t1, t2;
		for (int i = 0; i < 16; i++) w[i] = blk[i];
		for (int i = 16; i < 64; i++) begin
			w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		end
		for (int i = 0; i < 8; i++) v[i] = hash_state[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(i) + w[i];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int j = 7; j > 0; j--) v[j] = v[j-1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
	endtask

	task automatic append_word(input sha_pkg::word_t w);
		blk[fill] = w;
		fill++;
		if (fill == 16) begin
			fold_block();
			fill = 0;
		end
	endtask

	task automatic absorb_beat(input sha_pkg::word_t d, input logic [2:0] cnt, input logic fin);
		int unsigned nb;
		sha_pkg::word_t mask;
		if (!fin) begin
			bit_len += 32;
			append_word(d);
			return;
		end
		nb = (cnt > 4) ? 4 : cnt;
		bit_len += nb * 8;
		if (nb == 4) begin
			append_word(d);
			append_word(sha_pkg::MarkWord);
		end else begin
			mask = (nb == 0) ? '0 : (32'hffffffff << (32 - 8 * nb));
			append_word((d & mask) | (sha_pkg::word_t'(sha_pkg::MarkByte) << (24 - 8 * nb)));
		end
		if (fill > 14) while (fill != 0) append_word('0);
		while (fill < 14) append_word('0);
		append_word(bit_len[63:32]);
		append_word(bit_len[31:0]);
		for (int i = 0; i < 8; i++) digest_queue.push_back('{hash_state[i], 3'(i), i == 7});
		for (int i = 0; i < 8; i++) hash_state[i] = iv(i);
		fill = 0;
		bit_len = '0;
	endtask

	digest_beat_t exp_beat;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) hash_state[i] = iv(i);
			fill = 0;
			bit_len = '0;
			digest_queue.delete();
			fail_count = 0;
			messages_hashed = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (digest_queue.size() == 0) begin
					$error("unexpected digest beat %h", digest_word);
					fail_count++;
				end else begin
					exp_beat = digest_queue.pop_front();
					if (digest_word !== exp_beat.word) begin
						$error("digest_word expected %h actual %h", exp_beat.word, digest_word);
						fail_count++;
					end
					if (word_index !== exp_beat.idx) begin
						$error("word_index expected %0d actual %0d", exp_beat.idx, word_index);
						fail_count++;
					end
					if (last_word !== exp_beat.fin) begin
						$error("last_word expected %0b actual %0b", exp_beat.fin, last_word);
						fail_count++;
					end
					if (last_word === 1'b1) messages_hashed++;
				end
			end
			if (in_valid && !in_stall) absorb_beat(data_word, byte_count, is_last);
		end
		pending_digest_words = digest_queue.size();
	end
endmodule

// ===== tb/tb.sv =====
module tb;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        is_last;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	int          fail_count;
	int          pending_digest_words;
	int          messages_hashed;

	localparam int unsigned HoldLen = 400;

	// idle percentages, changed per phase
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	// long receiver hold-off: requests counted by the stimulus, cycles by the receiver
	int unsigned hold_req;
	int unsigned hold_ack;
	int unsigned hold_cycles;
	int          beats_sent;

	sha256_hash_engine DUT (.*);

	sha256_checker u_checker (.*);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: random stall, or a long hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_ack <= 0;
			hold_cycles <= 0;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_cycles <= HoldLen;
			out_stall <= 1'b1;
		end else if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// drive one beat, hold it until accepted; random idle gap first
	task automatic send_beat(input logic [31:0] d, input logic [2:0] cnt, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		data_word  <= d;
		byte_count <= cnt;
		is_last    <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		beats_sent++;
	endtask

	// a message: n full beats then a last beat with the given byte count
	task automatic send_message(input int n, input logic [2:0] cnt);
		for (int i = 0; i < n; i++) send_beat($urandom, 3'($urandom), 1'b0);
		send_beat($urandom, cnt, 1'b1);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_digest_words != 0) @(posedge clk);
	endtask

	int msg_len;

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_word = '0;
		byte_count = '0;
		is_last = 1'b0;
		send_idle_pct = 37;
		recv_idle_pct = 47;
		hold_req = 0;
		beats_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, each byte count, saturation, padding boundaries at 14 and 16 words
		send_beat(32'hffffffff, 3'd0, 1'b1);
		send_beat(32'hffffffff, 3'd1, 1'b1);
		send_beat(32'h00000000, 3'd2, 1'b1);
		send_beat(32'h61626300, 3'd3, 1'b1);
		send_beat(32'hffffffff, 3'd4, 1'b1);
		send_beat(32'haaaaaaaa, 3'd7, 1'b1);
		send_beat(32'h55555555, 3'd5, 1'b1);
		send_message(13, 3'd3);
		send_message(14, 3'd4);
		drain();

		// random phase one, sender idles 37%, receiver 47%
		while (beats_sent < 110) begin
			msg_len = ($urandom_range(9) == 0) ? $urandom_range(13, 33) : $urandom_range(0, 6);
			send_message(msg_len, 3'($urandom));
		end
		drain();

		// long receiver hold-off while the sender keeps pushing
		send_idle_pct = 0;
		hold_req = hold_req + 1;
		for (int i = 0; i < 4; i++) send_message($urandom_range(0, 3), 3'($urandom));
		drain();

		// phase two: roles swapped
		send_idle_pct = 47;
		recv_idle_pct = 37;
		while (beats_sent < 190) begin
			msg_len = ($urandom_range(9) == 0) ? $urandom_range(13, 33) : $urandom_range(0, 6);
			send_message(msg_len, 3'($urandom));
		end
		drain();

		// phase three: no idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (beats_sent < 260) begin
			msg_len = ($urandom_range(9) == 0) ? $urandom_range(13, 33) : $urandom_range(0, 6);
			send_message(msg_len, 3'($urandom));
		end
		drain();
		repeat (200) @(posedge clk);

		$display("run covered %0d input beats and %0d digests, byte counts 0..7 and padding edges",
			beats_sent, messages_hashed);
		if (fail_count == 0) begin
			$display("sha256_hash_engine verification clean");
		end else begin
			$display("sha256_hash_engine verification failed");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("sha256_hash_engine verification failed");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/sha_pkg.sv
rtl/sha_fifo.sv
rtl/sha_front.sv
rtl/sha_core.sv
rtl/sha256_hash_engine.sv
tb/sha256_checker.sv
tb/tb.sv
